FILE: rtl/telnet_command_filter_defines.svh
// Assertion macros for the telnet command filter checks
`ifndef TELNET_COMMAND_FILTER_DEFINES_SVH
`define TELNET_COMMAND_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("telnet_command_filter check failed");

// next-cycle implication, sampled on clk, off during reset
`define TCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("telnet_command_filter check failed");

`endif

FILE: rtl/tcf_pkg.sv
// Shared types, telnet codes and defaults for the telnet command filter
package tcf_pkg;

    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_DO   = 8'd253;
    localparam logic [7:0] CODE_WONT = 8'd252;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;

    localparam logic DEST_APP  = 1'b0;
    localparam logic DEST_PEER = 1'b1;

    localparam int TCF_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       is_reply;
        logic [7:0] verb;
        logic [7:0] value;
    } tcf_job_t;

endpackage

FILE: rtl/tcf_front.sv
// Receive parser: classifies incoming bytes and posts data and reply jobs
module tcf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_in,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               job_full,
    output logic               job_push,
    output tcf_pkg::tcf_job_t  job
);
    import tcf_pkg::*;

    localparam logic [2:0] PS_DATA   = 3'd0;
    localparam logic [2:0] PS_IAC    = 3'd1;
    localparam logic [2:0] PS_OPT    = 3'd2;
    localparam logic [2:0] PS_SUB    = 3'd3;
    localparam logic [2:0] PS_SUBIAC = 3'd4;

    logic [2:0] parse_state_reg;
    logic [2:0] parse_state_next;
    logic [7:0] pending_verb_reg;
    logic [7:0] pending_verb_next;
    logic       reply_enable_reg;
    logic       accept;
    logic       found;

    assign in_stall = job_full;
    assign accept   = in_valid && !job_full;
    assign job_push = accept && found;

    always_comb
    begin
        parse_state_next  = parse_state_reg;
        pending_verb_next = pending_verb_reg;
        found             = 1'b0;
        job.is_reply      = 1'b0;
        job.verb          = CODE_WONT;
        job.value         = byte_in;
        case (parse_state_reg)
            PS_DATA:
            begin
                if (byte_in == CODE_IAC)
                begin
                    parse_state_next = PS_IAC;
                end
                else
                begin
                    found = 1'b1;
                end
            end
            PS_IAC:
            begin
                if (byte_in == CODE_IAC)
                begin
                    found            = 1'b1;
                    parse_state_next = PS_DATA;
                end
                else if (byte_in == CODE_WILL || byte_in == CODE_WONT ||
                         byte_in == CODE_DO || byte_in == CODE_DONT)
                begin
                    pending_verb_next = byte_in;
                    parse_state_next  = PS_OPT;
                end
                else if (byte_in == CODE_SB)
                begin
                    parse_state_next = PS_SUB;
                end
                else
                begin
                    parse_state_next = PS_DATA;
                end
            end
            PS_OPT:
            begin
                job.is_reply = 1'b1;
                if (pending_verb_reg == CODE_DO)
                begin
                    found    = reply_enable_reg;
                    job.verb = (byte_in == OPT_ECHO || byte_in == OPT_SGA) ? CODE_WILL
                                                                           : CODE_WONT;
                end
                else if (pending_verb_reg == CODE_WILL)
                begin
                    found    = reply_enable_reg;
                    job.verb = (byte_in == OPT_SGA) ? CODE_DO : CODE_DONT;
                end
                parse_state_next = PS_DATA;
            end
            PS_SUB:
            begin
                if (byte_in == CODE_IAC)
                begin
                    parse_state_next = PS_SUBIAC;
                end
            end
            PS_SUBIAC:
            begin
                parse_state_next = (byte_in == CODE_SE) ? PS_DATA : PS_SUB;
            end
            default:
            begin
                parse_state_next = PS_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg  <= PS_DATA;
            pending_verb_reg <= 8'd0;
            reply_enable_reg <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                parse_state_reg  <= parse_state_next;
                pending_verb_reg <= pending_verb_next;
            end
            if (cfg_wr_en)
            begin
                reply_enable_reg <= cfg_wr_data;
            end
        end
    end

endmodule

FILE: rtl/tcf_queue.sv
// Job queue between the parser and the beat emitter
module tcf_queue #(
    parameter int DEPTH = tcf_pkg::TCF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tcf_pkg::tcf_job_t  push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output tcf_pkg::tcf_job_t  head_job
);
    import tcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tcf_job_t          slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

FILE: rtl/tcf_back.sv
// Beat emitter: turns queued jobs into output beats through an output register
module tcf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  tcf_pkg::tcf_job_t  head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               destination,
    output logic [7:0]         byte_out,
    output logic               last_of_run
);
    import tcf_pkg::*;

    localparam logic [1:0] BEAT_IAC  = 2'd0;
    localparam logic [1:0] BEAT_VERB = 2'd1;
    localparam logic [1:0] BEAT_OPT  = 2'd2;

    logic       out_valid_reg;
    logic       destination_reg;
    logic [7:0] byte_out_reg;
    logic       last_reg;
    logic [1:0] beat_reg;
    logic       load_ok;
    logic       load;
    logic       beat_dest;
    logic [7:0] beat_byte;
    logic       beat_last;

    assign load_ok = !out_valid_reg || !out_stall;
    assign load    = load_ok && head_valid;
    assign pop     = load && beat_last;

    always_comb
    begin
        beat_dest = DEST_APP;
        beat_byte = head_job.value;
        beat_last = 1'b1;
        if (head_job.is_reply)
        begin
            beat_dest = DEST_PEER;
            case (beat_reg)
                BEAT_IAC:
                begin
                    beat_byte = CODE_IAC;
                    beat_last = 1'b0;
                end
                BEAT_VERB:
                begin
                    beat_byte = head_job.verb;
                    beat_last = 1'b0;
                end
                BEAT_OPT:
                begin
                    beat_byte = head_job.value;
                end
                default:
                begin
                    beat_byte = head_job.value;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            destination_reg <= beat_dest;
            byte_out_reg    <= beat_byte;
            last_reg        <= beat_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_IAC;
        end
        else
        begin
            if (load_ok)
            begin
                out_valid_reg <= head_valid;
            end
            if (load)
            begin
                beat_reg <= beat_last ? BEAT_IAC : beat_reg + 2'd1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign destination = destination_reg;
    assign byte_out    = byte_out_reg;
    assign last_of_run = last_reg;

endmodule

FILE: rtl/telnet_command_filter.sv
// Telnet receive filter top level: parser, job queue and beat emitter
//
// Input channel: one received byte per beat on byte_in (in_valid / in_stall).
// Output channel: result beats on destination, byte_out, last_of_run
// (out_valid / out_stall). destination 0 is a data byte for the application,
// 1 a reply byte for the peer; last_of_run marks the final beat of an input.
// reply_enable is set via cfg_wr_en / cfg_wr_data; the user must do so only
// while idle, which the block does not enforce. A result beat passes through
// the job queue and then the output register of the emitter.
// Throughput: one input byte per cycle while in_stall is low; a data job
// takes one output beat and a negotiation reply three (IAC, verb, option),
// all through the single output register of the emitter. The job queue
// (QUEUE_DEPTH entries) absorbs jobs; in_stall rises only while it is full.
// Reset clears the parser to the data state, sets reply_enable to 1 and
// empties the queue and the output register.
// While out_stall is high the output beat holds, the queue fills, and then
// the input side stalls.
module telnet_command_filter #(
    parameter int QUEUE_DEPTH = tcf_pkg::TCF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       destination,
    output logic [7:0] byte_out,
    output logic       last_of_run
);
    import tcf_pkg::*;

    tcf_job_t push_job;
    tcf_job_t head_job;
    logic     job_push;
    logic     job_full;
    logic     head_valid;
    logic     job_pop;

    tcf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .byte_in     (byte_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_full    (job_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    tcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (push_job),
        .full       (job_full),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tcf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (job_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .destination (destination),
        .byte_out    (byte_out),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/tcf_checker.sv
// Port-level checks for the telnet command filter, bound to the top level
`include "telnet_command_filter_defines.svh"

module tcf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       destination,
    input logic [7:0] byte_out,
    input logic       last_of_run
);
    import tcf_pkg::*;

    logic out_beat;

    assign out_beat = out_valid && !out_stall;

    `TCF_ASSERT_NEXT(a_stalled_beat_holds, out_valid && out_stall,
        out_valid && $stable(byte_out) && $stable(destination) && $stable(last_of_run))

    `TCF_ASSERT_NOW(a_data_beat_is_last, out_valid && destination == DEST_APP, last_of_run)

    `TCF_ASSERT_NEXT(a_reply_continues, out_beat && destination == DEST_PEER && !last_of_run,
        out_valid && destination == DEST_PEER)

    `TCF_ASSERT_NOW(a_reply_first_is_iac,
        out_valid && destination == DEST_PEER && !last_of_run && $past(out_valid && last_of_run),
        byte_out == CODE_IAC)

endmodule

bind telnet_command_filter tcf_checker u_tcf_checker (.*);
